### rtl/mpa_pkg.sv
// ----------------------------------------------------------------------------
// Max pooling with argmax: shared package
// Types, register indexes and default sizes used by the pooling core and its
// window cells.
// ----------------------------------------------------------------------------
package mpa_pkg;

	localparam int DEF_MAX_WIDTH   = 64;
	localparam int DEF_MAX_HEIGHT  = 64;
	localparam int DEF_MAX_POOL    = 4;
	localparam int DEF_MAX_PLANES  = 256;
	localparam int DEF_SAMPLE_BITS = 16;

	localparam int IDX_BITS     = 20;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DAT_BITS = 9;

	localparam logic [CFG_IDX_BITS-1:0] REG_POOL_SIZE    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_STEP_SIZE    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_COUNT  = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_REDUCE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic clear;
		logic sample_en;
	} cell_ctrl_t;

endpackage

### rtl/mpa_cell.sv
// ----------------------------------------------------------------------------
// Max pooling with argmax: window row cell
// Holds one row slot of the line store, tracks the first maximum of its window
// row and merges it into the running result handed along the chain.
// ----------------------------------------------------------------------------
module mpa_cell import mpa_pkg::*; #(
	parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int MAX_POOL    = DEF_MAX_POOL,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	localparam int XW = $clog2(MAX_WIDTH),
	localparam int SW = $clog2(MAX_POOL)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [XW-1:0]                 wr_addr,
	input  logic signed [SAMPLE_BITS-1:0] wr_data,
	input  logic [XW-1:0]                 rd_addr,
	input  cell_ctrl_t                    ctrl,
	input  logic [XW-1:0]                 col,
	input  logic [SW-1:0]                 rank,
	input  logic                          active,
	input  logic                          in_valid,
	input  logic signed [SAMPLE_BITS-1:0] in_value,
	input  logic [SW-1:0]                 in_rank,
	input  logic [XW-1:0]                 in_col,
	output logic                          out_valid,
	output logic signed [SAMPLE_BITS-1:0] out_value,
	output logic [SW-1:0]                 out_rank,
	output logic [XW-1:0]                 out_col
);

	logic signed [SAMPLE_BITS-1:0] mem [MAX_WIDTH];
	logic signed [SAMPLE_BITS-1:0] rd_q;
	logic signed [SAMPLE_BITS-1:0] best_q;
	logic [XW-1:0]                 bcol_q;
	logic                          seen_q;
	logic                          acc_valid_q;
	logic signed [SAMPLE_BITS-1:0] acc_value_q;
	logic [SW-1:0]                 acc_rank_q;
	logic [XW-1:0]                 acc_col_q;
	logic                          own;
	logic                          take_own;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (ctrl.clear) begin
			seen_q <= 1'b0;
		end else if (ctrl.sample_en && active) begin
			seen_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.sample_en && active && (!seen_q || rd_q > best_q)) begin
			best_q <= rd_q;
			bcol_q <= col;
		end
	end

	assign own = active && seen_q;
	assign take_own = own && (!in_valid || best_q > in_value ||
		(best_q == in_value && rank < in_rank));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_valid_q <= 1'b0;
		end else begin
			acc_valid_q <= own || in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_own) begin
			acc_value_q <= best_q;
			acc_rank_q  <= rank;
			acc_col_q   <= bcol_q;
		end else begin
			acc_value_q <= in_value;
			acc_rank_q  <= in_rank;
			acc_col_q   <= in_col;
		end
	end

	assign out_valid = acc_valid_q;
	assign out_value = acc_value_q;
	assign out_rank  = acc_rank_q;
	assign out_col   = acc_col_q;

endmodule

### rtl/max_pooling_with_argmax_core.sv
// A sample that completes no window does not stall the input.
// A sample that completes a window stalls the input while the window is scanned and reduced:
// one line store read per window column, then one step per cell along the chain, and then
// until the output register is free to take the result.
// The result waits in an output register, so the next sample is taken while it waits.
// Reset clears the counters and handshake state and loads the default configuration; the line store is not cleared.
// ----------------------------------------------------------------------------
// Max pooling with argmax: core
// Streams samples into a line store split over a chain of row cells and emits
// each completed window's maximum with the global index of its first maximum.
// ----------------------------------------------------------------------------
module max_pooling_with_argmax_core import mpa_pkg::*; #(
	parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
	parameter int MAX_POOL    = DEF_MAX_POOL,
	parameter int MAX_PLANES  = DEF_MAX_PLANES,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [CFG_DAT_BITS-1:0]       cfg_data,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic signed [SAMPLE_BITS-1:0] max_value,
	output logic [IDX_BITS-1:0]           source_index,
	output logic                          last_of_plane
);

	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int YW  = $clog2(MAX_HEIGHT);
	localparam int SW  = $clog2(MAX_POOL);
	localparam int PW  = $clog2(MAX_POOL + 1);
	localparam int NW  = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

	logic [2:0] pool_q;
	logic [2:0] step_q;
	logic [6:0] width_q;
	logic [6:0] height_q;
	logic [8:0] planes_q;

	logic [XW-1:0]       x_q;
	logic [YW-1:0]       y_q;
	logic [NW-1:0]       plane_q;
	logic [SW-1:0]       colph_q;
	logic [SW-1:0]       rowph_q;
	logic [SW-1:0]       slot_q;
	logic [IDX_BITS-1:0] base_q;

	logic [XW-1:0]       x0_q;
	logic [YW-1:0]       y0_q;
	logic [SW-1:0]       slot0_q;
	logic                wlast_q;
	logic [IDX_BITS-1:0] wbase_q;

	state_t    state_q, state_d;
	logic [PW-1:0] cnt_q;
	logic          en_s1;
	logic [XW-1:0] col_s1;

	logic                          res_valid_q;
	logic signed [SAMPLE_BITS-1:0] res_value_q;
	logic [IDX_BITS-1:0]           res_index_q;
	logic                          res_last_q;

	logic [31:0] pi, si, wi, hi, npi, xi, yi;
	logic        win;
	logic        cfg_we;
	logic        accept;
	logic        load_out;
	cell_ctrl_t  ctrl;
	logic [XW-1:0] rd_addr;

	logic [XW-1:0]       x_n;
	logic [YW-1:0]       y_n;
	logic [NW-1:0]       plane_n;
	logic [SW-1:0]       colph_n;
	logic [SW-1:0]       rowph_n;
	logic [SW-1:0]       slot_n;
	logic [IDX_BITS-1:0] base_n;
	logic [IDX_BITS-1:0] hw;
	logic [31:0]         slot0_i;
	logic [IDX_BITS-1:0] index_d;

	logic                          ch_valid [MAX_POOL+1];
	logic signed [SAMPLE_BITS-1:0] ch_value [MAX_POOL+1];
	logic [SW-1:0]                 ch_rank  [MAX_POOL+1];
	logic [XW-1:0]                 ch_col   [MAX_POOL+1];

	assign pi  = (pool_q == 3'd0) ? 32'd1 :
		((32'(pool_q) > MAX_POOL) ? 32'(MAX_POOL) : 32'(pool_q));
	assign si  = (step_q == 3'd0) ? 32'd1 :
		((32'(step_q) > MAX_POOL) ? 32'(MAX_POOL) : 32'(step_q));
	assign wi  = (width_q == 7'd0) ? 32'd1 :
		((32'(width_q) > MAX_WIDTH) ? 32'(MAX_WIDTH) : 32'(width_q));
	assign hi  = (height_q == 7'd0) ? 32'd1 :
		((32'(height_q) > MAX_HEIGHT) ? 32'(MAX_HEIGHT) : 32'(height_q));
	assign npi = (planes_q == 9'd0) ? 32'd1 :
		((32'(planes_q) > MAX_PLANES) ? 32'(MAX_PLANES) : 32'(planes_q));
	assign xi  = 32'(x_q);
	assign yi  = 32'(y_q);
	assign hw  = IDX_BITS'(hi * wi);

	assign win = (pi <= wi) && (pi <= hi) && (xi + 32'd1 >= pi) && (yi + 32'd1 >= pi) &&
		(colph_q == '0) && (rowph_q == '0);

	assign cfg_ready    = 1'b1;
	assign cfg_we       = cfg_valid && cfg_ready;
	assign sample_stall = (state_q != ST_IDLE);
	assign accept       = sample_valid && !sample_stall;

	always_comb begin
		x_n     = x_q;
		y_n     = y_q;
		plane_n = plane_q;
		colph_n = colph_q;
		rowph_n = rowph_q;
		slot_n  = slot_q;
		base_n  = base_q;
		if (xi + 32'd1 >= pi) begin
			colph_n = (32'(colph_q) + 32'd1 >= si) ? '0 : colph_q + 1'b1;
		end
		if (xi + 32'd1 >= wi) begin
			x_n     = '0;
			colph_n = '0;
			if (yi + 32'd1 >= pi) begin
				rowph_n = (32'(rowph_q) + 32'd1 >= si) ? '0 : rowph_q + 1'b1;
			end
			slot_n = (32'(slot_q) + 32'd1 >= MAX_POOL) ? '0 : slot_q + 1'b1;
			if (yi + 32'd1 >= hi) begin
				y_n     = '0;
				rowph_n = '0;
				slot_n  = '0;
				if (32'(plane_q) + 32'd1 >= npi) begin
					plane_n = '0;
					base_n  = '0;
				end else begin
					plane_n = plane_q + 1'b1;
					base_n  = base_q + hw;
				end
			end else begin
				y_n = y_q + 1'b1;
			end
		end else begin
			x_n = x_q + 1'b1;
		end
	end

	assign slot0_i = 32'(slot_q) + 32'(MAX_POOL) + 32'd1 - pi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q   <= 3'd2;
			step_q   <= 3'd2;
			width_q  <= 7'd64;
			height_q <= 7'd64;
			planes_q <= 9'd1;
			x_q      <= '0;
			y_q      <= '0;
			plane_q  <= '0;
			colph_q  <= '0;
			rowph_q  <= '0;
			slot_q   <= '0;
			base_q   <= '0;
		end else if (cfg_we && cfg_index <= REG_PLANE_COUNT) begin
			unique case (cfg_index)
				REG_POOL_SIZE:    pool_q   <= cfg_data[2:0];
				REG_STEP_SIZE:    step_q   <= cfg_data[2:0];
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[6:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[6:0];
				REG_PLANE_COUNT:  planes_q <= cfg_data;
				default:          pool_q   <= pool_q;
			endcase
			x_q     <= '0;
			y_q     <= '0;
			plane_q <= '0;
			colph_q <= '0;
			rowph_q <= '0;
			slot_q  <= '0;
			base_q  <= '0;
		end else if (accept) begin
			x_q     <= x_n;
			y_q     <= y_n;
			plane_q <= plane_n;
			colph_q <= colph_n;
			rowph_q <= rowph_n;
			slot_q  <= slot_n;
			base_q  <= base_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && win) begin
			x0_q    <= XW'(xi + 32'd1 - pi);
			y0_q    <= YW'(yi + 32'd1 - pi);
			slot0_q <= SW'((slot0_i >= MAX_POOL) ? slot0_i - 32'(MAX_POOL) : slot0_i);
			wlast_q <= (xi + si >= wi) && (yi + si >= hi);
			wbase_q <= base_q;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept && win) state_d = ST_SCAN;
			ST_SCAN:   if (32'(cnt_q) + 32'd1 >= pi) state_d = ST_REDUCE;
			ST_REDUCE: if (32'(cnt_q) >= MAX_POOL) state_d = ST_EMIT;
			ST_EMIT:   if (!res_valid_q || !result_stall) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl.clear     = accept && win;
		ctrl.sample_en = en_s1;
		load_out       = (state_q == ST_EMIT) && (!res_valid_q || !result_stall);
		rd_addr        = x0_q + XW'(cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			en_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? '0 : cnt_q + 1'b1;
			en_s1   <= (state_q == ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		col_s1 <= rd_addr;
	end

	assign ch_valid[0] = 1'b0;
	assign ch_value[0] = '0;
	assign ch_rank[0]  = '0;
	assign ch_col[0]   = '0;

	for (genvar k = 0; k < MAX_POOL; k++) begin : g_cell
		logic [SW-1:0] rank;
		assign rank = (k >= 32'(slot0_q)) ? SW'(k - 32'(slot0_q)) :
			SW'(k + MAX_POOL - 32'(slot0_q));

		mpa_cell #(
			.MAX_WIDTH  (MAX_WIDTH),
			.MAX_POOL   (MAX_POOL),
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (accept && (32'(slot_q) == k)),
			.wr_addr  (x_q),
			.wr_data  (sample),
			.rd_addr  (rd_addr),
			.ctrl     (ctrl),
			.col      (col_s1),
			.rank     (rank),
			.active   (32'(rank) < pi),
			.in_valid (ch_valid[k]),
			.in_value (ch_value[k]),
			.in_rank  (ch_rank[k]),
			.in_col   (ch_col[k]),
			.out_valid(ch_valid[k+1]),
			.out_value(ch_value[k+1]),
			.out_rank (ch_rank[k+1]),
			.out_col  (ch_col[k+1])
		);
	end

	assign index_d = wbase_q + IDX_BITS'((32'(y0_q) + 32'(ch_rank[MAX_POOL])) * wi) +
		IDX_BITS'(ch_col[MAX_POOL]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_value_q <= ch_value[MAX_POOL];
			res_index_q <= index_d;
			res_last_q  <= wlast_q;
		end
	end

	assign result_valid  = res_valid_q;
	assign max_value     = res_value_q;
	assign source_index  = res_index_q;
	assign last_of_plane = res_last_q;

endmodule

### rtl/mpa_checker.sv
// ----------------------------------------------------------------------------
// Max pooling with argmax: port checker
// Watches the core's ports for handshake and sequencing errors.
// ----------------------------------------------------------------------------
module mpa_checker import mpa_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_ready,
	input logic                          sample_stall,
	input logic                          result_valid,
	input logic                          result_stall,
	input logic signed [SAMPLE_BITS-1:0] max_value,
	input logic [IDX_BITS-1:0]           source_index
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("Result item dropped while stalled.");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(max_value) && $stable(source_index))
		else $error("Result item changed while stalled.");

	a_busy_before_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(sample_stall))
		else $error("Result item appeared without a window scan.");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("Configuration port not ready.");

endmodule

bind max_pooling_with_argmax_core mpa_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mpa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_ready   (cfg_ready),
	.sample_stall(sample_stall),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.max_value   (max_value),
	.source_index(source_index)
);
